// ===== design/hdq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hdq_pkg
// Shared types and constants of the tree decoder with dequantization.
// ----------------------------------------------------------------------------
package hdq_pkg;

  localparam int unsigned MaxNodesDef   = 512;
  localparam int unsigned MaxSymbolsDef = 256;

  localparam int unsigned AddrW   = 9;
  localparam int unsigned SymW    = 8;
  localparam int unsigned ValW    = 32;
  localparam int unsigned WidthW  = 31;
  localparam int unsigned FuncW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 40;

  localparam logic [FuncW-1:0] FUNC_WRITE   = 2'd0;
  localparam logic [FuncW-1:0] FUNC_DECODE  = 2'd1;
  localparam logic [FuncW-1:0] FUNC_RESTART = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_BASE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_COUNT = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_ROOT  = 2'd3;

  typedef struct packed {
    logic [AddrW-1:0] left;
    logic [AddrW-1:0] right;
    logic             leaf;
    logic [SymW-1:0]  symbol;
  } node_t;

endpackage
`default_nettype wire

// ===== design/huffman_dequant_decoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_dequant_decoder_top
// Walks a code tree held in a node memory, one stream bit per step, and
// returns each decoded bucket index with its dequantized Q16.16 value.
// ----------------------------------------------------------------------------
// Node writes, restarts and bytes that arrive after the stream is finished
// are handled in the idle state. Any other data byte is accepted, then takes
// one step per bit consumed (at most eight), one more step for each value
// found below the root, and a flush state to release its last result; the
// output can hold off a value and stall this. No new byte is taken until the
// walk is back in idle. Every tree step goes through the node memory's single read port.
// Reset restores the register defaults and clears the walk; node memory
// contents stay undefined until written.
module huffman_dequant_decoder_top #(
  parameter int unsigned MAX_NODES   = hdq_pkg::MaxNodesDef,
  parameter int unsigned MAX_SYMBOLS = hdq_pkg::MaxSymbolsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [hdq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [hdq_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // data_byte[7:0], node_addr[16:8], left_child[25:17], right_child[34:26],
  // node_is_leaf[35], leaf_symbol[43:36], zero fill[47:44]
  input  wire logic [hdq_pkg::InDataW-1:0]  s_axis_tdata_i,
  // func[1:0]
  input  wire logic [hdq_pkg::FuncW-1:0]    s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // symbol_index[7:0], value[39:8]
  output logic [hdq_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // last_of_run
  output logic                              m_axis_tlast_o,
  // stream_done
  output logic                              m_axis_tuser_o
);
  import hdq_pkg::*;

  localparam int unsigned NodeAw = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic [SymW-1:0] SymSat = SymW'(MAX_SYMBOLS - 1);
  localparam logic signed [40:0] SatMax = 41'sd2147483647;
  localparam logic signed [40:0] SatMin = -41'sd2147483648;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_FLUSH
  } state_e;

  function automatic logic [NodeAw-1:0] node_idx(input logic [AddrW-1:0] a);
    logic [NodeAw+AddrW-1:0] ext;
    ext = {{NodeAw{1'b0}}, a};
    return ext[NodeAw-1:0];
  endfunction

  function automatic logic addr_ok(input logic [AddrW-1:0] a);
    return 32'(a) < 32'(MAX_NODES);
  endfunction

  state_e              state_q;
  logic [AddrW-1:0]    cur_q;
  logic [31:0]         cnt_q;
  logic [7:0]          byte_q;
  logic [3:0]          rem_q;
  logic                from_child_q;

  logic [ValW-1:0]     base_q;
  logic [WidthW-1:0]   bw_q;
  logic [31:0]         ec_q;
  logic [AddrW-1:0]    root_q;

  logic                pend_vld_q;
  logic [SymW-1:0]     pend_sym_q;
  logic [38:0]         pend_prod_q;
  logic                pend_done_q;

  logic                out_vld_q;
  logic [SymW-1:0]     out_sym_q;
  logic [ValW-1:0]     out_val_q;
  logic                out_last_q;
  logic                out_done_q;

  node_t               node_mem [MAX_NODES];
  node_t               rd_data_q;
  logic                rd_oor_q;

  logic                acc_in;
  logic [FuncW-1:0]    in_func;
  logic [7:0]          in_byte;
  logic [AddrW-1:0]    in_addr;
  node_t               wr_entry;
  logic                wr_en;
  logic                rd_en;
  logic [AddrW-1:0]    rd_addr;
  node_t               entry;
  logic [AddrW-1:0]    child;
  logic                out_free;
  logic                out_load;
  logic                emit_ok;
  logic                step_emit;
  logic                step_move;
  logic [31:0]         cnt_inc;
  logic                inc_done;
  logic [3:0]          rem_after;
  logic signed [40:0]  val_sum;
  logic [ValW-1:0]     val_sat;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign acc_in          = s_axis_tvalid_i && s_axis_tready_o;

  assign in_func         = s_axis_tuser_i;
  assign in_byte         = s_axis_tdata_i[7:0];
  assign in_addr         = s_axis_tdata_i[16:8];
  assign wr_entry.left   = s_axis_tdata_i[25:17];
  assign wr_entry.right  = s_axis_tdata_i[34:26];
  assign wr_entry.leaf   = s_axis_tdata_i[35];
  assign wr_entry.symbol = (32'(s_axis_tdata_i[43:36]) >= 32'(MAX_SYMBOLS)) ?
                           SymSat : s_axis_tdata_i[43:36];
  assign wr_en = acc_in && (in_func == FUNC_WRITE) && addr_ok(in_addr);

  assign entry     = rd_oor_q ? '0 : rd_data_q;
  assign child     = byte_q[7] ? entry.right : entry.left;
  assign out_free  = !out_vld_q || m_axis_tready_i;
  assign emit_ok   = !pend_vld_q || out_free;
  assign out_load  = (step_emit && pend_vld_q) ||
                     ((state_q == S_FLUSH) && pend_vld_q && out_free);
  assign cnt_inc   = cnt_q + 32'd1;
  assign inc_done  = ({1'b0, cnt_inc} >= {1'b0, ec_q});
  assign rem_after = from_child_q ? rem_q : rem_q - 4'd1;

  assign val_sum = $signed({{9{base_q[31]}}, base_q}) + $signed({2'b00, pend_prod_q})
                 + $signed({11'd0, bw_q[WidthW-1:1]});
  assign val_sat = (val_sum > SatMax) ? 32'h7FFF_FFFF :
                   (val_sum < SatMin) ? 32'h8000_0000 : val_sum[31:0];

  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = cur_q;
    step_emit = 1'b0;
    step_move = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (acc_in && (in_func == FUNC_DECODE) && (cnt_q < ec_q)) begin
          rd_en = 1'b1;
        end
      end
      S_STEP: begin
        if (entry.leaf) begin
          if (emit_ok) begin
            step_emit = 1'b1;
            rd_en     = 1'b1;
            rd_addr   = root_q;
          end
        end else if (rem_q != 4'd0) begin
          step_move = 1'b1;
          rd_en     = 1'b1;
          rd_addr   = child;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      node_mem[node_idx(in_addr)] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_q <= node_mem[node_idx(rd_addr)];
      rd_oor_q  <= !addr_ok(rd_addr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_q        <= '0;
      cnt_q        <= '0;
      byte_q       <= '0;
      rem_q        <= '0;
      from_child_q <= 1'b0;
      base_q       <= '0;
      bw_q         <= 31'd65536;
      ec_q         <= '0;
      root_q       <= '0;
      pend_vld_q   <= 1'b0;
      pend_sym_q   <= '0;
      pend_prod_q  <= '0;
      pend_done_q  <= 1'b0;
      out_vld_q    <= 1'b0;
      out_sym_q    <= '0;
      out_val_q    <= '0;
      out_last_q   <= 1'b0;
      out_done_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_BASE:  base_q <= cfg_data_i;
          CFG_WIDTH: bw_q   <= cfg_data_i[WidthW-1:0];
          CFG_COUNT: ec_q   <= cfg_data_i;
          CFG_ROOT:  root_q <= cfg_data_i[AddrW-1:0];
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (acc_in) begin
            case (in_func)
              FUNC_DECODE: begin
                if (cnt_q < ec_q) begin
                  state_q      <= S_STEP;
                  byte_q       <= in_byte;
                  rem_q        <= 4'd8;
                  from_child_q <= 1'b0;
                end
              end
              FUNC_RESTART: begin
                cur_q <= root_q;
                cnt_q <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_STEP: begin
          if (step_emit) begin
            if (pend_vld_q) begin
              out_sym_q  <= pend_sym_q;
              out_val_q  <= val_sat;
              out_last_q <= 1'b0;
              out_done_q <= pend_done_q;
            end
            pend_vld_q   <= 1'b1;
            pend_sym_q   <= entry.symbol;
            pend_prod_q  <= {31'd0, entry.symbol} * {8'd0, bw_q};
            pend_done_q  <= inc_done;
            cnt_q        <= cnt_inc;
            cur_q        <= root_q;
            from_child_q <= 1'b0;
            rem_q        <= rem_after;
            if (!from_child_q) begin
              byte_q <= {byte_q[6:0], 1'b0};
            end
            if ((rem_after == 4'd0) || inc_done) begin
              state_q <= S_FLUSH;
            end
          end else if (step_move) begin
            cur_q        <= child;
            byte_q       <= {byte_q[6:0], 1'b0};
            rem_q        <= rem_q - 4'd1;
            from_child_q <= 1'b1;
          end else if (!entry.leaf) begin
            state_q <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!pend_vld_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_sym_q  <= pend_sym_q;
            out_val_q  <= val_sat;
            out_last_q <= 1'b1;
            out_done_q <= pend_done_q;
            pend_vld_q <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_val_q, out_sym_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_vld_q)
    else $error("pending result left over while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 4'd8)
    else $error("bit counter out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_STEP) && !from_child_q) |-> (rem_q != 4'd0))
    else $error("bit step started with no bits left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_emit && pend_vld_q) |=> (out_vld_q && !out_last_q))
    else $error("earlier result not moved to the output register");

endmodule
`default_nettype wire
